// File: rtl/pnri_pkg.sv
// Package for the polynomial Newton root iterator.
// Holds constants, the sequencer state type and status codes; no dependencies.
`default_nettype none
package pnri_pkg;
  localparam int MaxTermsDefault = 128;
  localparam int MaxSteps        = 64;
  localparam int CfgW            = 7;
  localparam logic [CfgW-1:0] DegreeReset = 7'd1;
  localparam logic [CfgW-1:0] IterReset   = 7'd10;
  localparam logic CfgIdxDegree = 1'b0;
  localparam logic CfgIdxIter   = 1'b1;
  localparam logic OpLoad  = 1'b0;
  localparam logic OpStart = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DZERO = 2'd1,
    STAT_SAT  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_MUL, S_ADD, S_DIVSET, S_DIV, S_FIN, S_OUT
  } state_t;
endpackage
`default_nettype wire

// File: rtl/polynomial_newton_root_iterator_core.sv
// Top level of the polynomial Newton root iterator.
// Uses pnri_pkg and the pnri_ram coefficient store.
//
// Usage: s_axis carries items; tuser is the opcode, tdata holds
// {coef_index, pad, coef_value, start_point} from bit 0 up. A load item
// writes one coefficient. A start item runs iteration_count (at most
// MaxSteps) Newton steps and emits one m_axis transfer per step; tlast
// marks the final step. tdata out: iterate_value[31:0], step_number[37:32],
// step_status[39:38]. Per step: a setup state, (degree+1) Horner terms,
// each a multiply state and an add/saturate state (RAM read overlapped),
// a divider setup state, a restoring divider (one quotient bit per cycle,
// DivBits bits), a finish state and an output state.
// A zero-derivative step skips the divider.
// One item is worked at a time; s_axis tready is low during a run, and for
// one cycle after a start with an iteration count of zero. When m_axis
// stalls, the result is held in the output register and the run pauses
// before presenting the next step.
// Reset (rst, synchronous) clears the sequencer, iterate and config to
// defaults; coefficients are undefined until loaded.
// Config: cfg_we writes register cfg_idx (0 degree, 1 iteration count).
`default_nettype none
module polynomial_newton_root_iterator_core #(
  parameter int MaxTerms = pnri_pkg::MaxTermsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // coef_index[6:0], zero[7], coef_value[39:8], start_point[71:40]
  input  wire logic [71:0] s_axis_tdata,
  // opcode
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // iterate_value[31:0], step_number[37:32], step_status[39:38]
  output logic [39:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [6:0]  cfg_data
);
  import pnri_pkg::*;
  localparam int AW = $clog2(MaxTerms);
  localparam int DegMaxInt = (MaxTerms - 1 > (1 << CfgW) - 1) ? (1 << CfgW) - 1
                                                                : MaxTerms - 1;
  localparam logic [CfgW-1:0] DegMax = CfgW'(DegMaxInt);
  localparam int DivBits = 48;

  state_t state, state_next;
  logic [CfgW-1:0] poly_degree, iteration_count;
  logic signed [31:0] x, p, d, coef;
  logic signed [63:0] prod_p, prod_d;
  logic [CfgW-1:0] term, deg_eff;
  logic [6:0] steps_left;
  logic [5:0] step_counter;
  logic sat;
  logic [5:0] div_cnt;
  logic [63:0] rem;
  logic [79:0] dvsr;
  logic [63:0] quo;
  logic q_neg;
  status_t res_st;
  logic [AW-1:0] raddr;
  logic load_we;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v,
                                               output logic f);
    f = 1'b0;
    if (v > 66'sd2147483647) begin f = 1'b1; sat32 = 32'sh7fffffff; end
    else if (v < -66'sd2147483648) begin f = 1'b1; sat32 = 32'sh80000000; end
    else sat32 = v[31:0];
  endfunction

  assign deg_eff = (poly_degree > DegMax) ? DegMax : poly_degree;
  assign s_axis_tready = (state == S_IDLE);
  assign load_we = s_axis_tvalid && s_axis_tready && s_axis_tuser == OpLoad
                   && int'(s_axis_tdata[6:0]) < MaxTerms;
  assign raddr = AW'(term);

  pnri_ram #(.Width(32), .Depth(MaxTerms)) u_coef (
    .clk(clk), .we(load_we), .waddr(AW'(s_axis_tdata[6:0])),
    .wdata(s_axis_tdata[39:8]), .raddr(raddr), .rdata(coef));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (s_axis_tvalid && s_axis_tuser == OpStart) state_next = S_FETCH;
      S_FETCH:  state_next = (steps_left == '0) ? S_IDLE : S_MUL;
      S_MUL:    state_next = S_ADD;
      S_ADD:    state_next = (term == '0) ? S_DIVSET : S_MUL;
      S_DIVSET: state_next = (d == '0) ? S_FIN : S_DIV;
      S_DIV:    state_next = (div_cnt == '0) ? S_FIN : S_DIV;
      S_FIN:    state_next = S_OUT;
      S_OUT:    if (!m_axis_tvalid || m_axis_tready) state_next = S_FETCH;
      default:  state_next = S_IDLE;
    endcase
  end

  logic signed [31:0] dn, pn, qs, xn;
  logic f1, f2, f3, f4;
  logic signed [63:0] pp_ext;
  always_comb begin
    dn = sat32(66'(prod_d >>> 16) + 66'(p), f1);
    pn = sat32(66'(prod_p >>> 16) + 66'(coef), f2);
    qs = sat32(q_neg ? -$signed({2'b0, quo}) : $signed({2'b0, quo}), f3);
    xn = sat32(66'(x) - 66'(qs), f4);
    pp_ext = 64'(p) <<< 16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      poly_degree <= DegreeReset;
      iteration_count <= IterReset;
      x <= '0;
      step_counter <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_idx == CfgIdxDegree) poly_degree <= cfg_data;
        else iteration_count <= cfg_data;
      end
      if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (s_axis_tvalid && s_axis_tuser == OpStart) begin
          x <= s_axis_tdata[71:40];
          step_counter <= '0;
          steps_left <= (iteration_count > 7'(MaxSteps)) ? 7'(MaxSteps)
                                                         : iteration_count;
        end
        S_FETCH: begin
          term <= deg_eff; p <= '0; d <= '0; sat <= 1'b0;
        end
        S_MUL: begin
          prod_d <= d * x;
          prod_p <= p * x;
        end
        S_ADD: begin
          d <= dn; p <= pn;
          sat <= sat | f1 | f2;
          if (term != '0) term <= term - 1'b1;
        end
        S_DIVSET: begin
          rem <= pp_ext[63] ? -pp_ext : pp_ext;
          dvsr <= (d[31] ? 80'(-64'(d)) : 80'(d)) << (DivBits - 1);
          q_neg <= p[31] ^ d[31];
          quo <= '0;
          div_cnt <= 6'(DivBits - 1);
        end
        S_DIV: begin
          if ({16'b0, rem} >= dvsr) begin
            rem <= rem - dvsr[63:0];
            quo <= {quo[62:0], 1'b1};
          end else begin
            quo <= {quo[62:0], 1'b0};
          end
          dvsr <= dvsr >> 1;
          if (div_cnt != '0) div_cnt <= div_cnt - 1'b1;
        end
        S_FIN: begin
          if (d == '0) begin
            res_st <= STAT_DZERO;
          end else begin
            x <= xn;
            res_st <= (sat | f3 | f4) ? STAT_SAT : STAT_OK;
          end
        end
        S_OUT: if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata <= {res_st, step_counter, x};
          m_axis_tlast <= (steps_left == 7'd1);
          step_counter <= step_counter + 1'b1;
          steps_left <= steps_left - 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/pnri_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pnri_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/pnri_checker.sv
// Port-level checker for the polynomial Newton root iterator, with bind.
// Depends on polynomial_newton_root_iterator_core.
`default_nettype none
module pnri_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[39:38] != 2'd3)
    else $error("bad status");
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("valid after reset");
  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready in the middle of a run");
endmodule

bind polynomial_newton_root_iterator_core pnri_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast));
`default_nettype wire

// File: tb/sv/polynomial_newton_root_iterator_core_test.sv
// Testbench for polynomial_newton_root_iterator_core: coefficient loads and Newton runs
// go through a directed table, then random phases. Each step is checked against a Q16.16
// predictor or a fixed expectation. Depends on pnri_pkg and the core RTL.
module polynomial_newton_root_iterator_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pnri_pkg::*;

  typedef struct {
    int          iterate;
    logic [5:0]  step;
    logic        last;
    status_t     status;
  } step_result_t;

  typedef struct {
    bit         is_cfg;
    logic       reg_idx;
    logic [6:0] reg_val;
    logic       op;
    logic [6:0] idx;
    int         coef;
    int         start;
    bit         has_exp;
    int         exp_x;
    status_t    exp_st;
  } stim_row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we = 0;
  logic        cfg_idx = 0;
  logic [6:0]  cfg_data = '0;

  polynomial_newton_root_iterator_core dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  int           coef_mem[MaxTermsDefault];
  logic [6:0]   degree_reg = DegreeReset;
  logic [6:0]   iter_reg = IterReset;
  step_result_t pending_steps[$];
  stim_row_t    table_rows[$];
  int           errors = 0;
  int           starts_sent = 0;
  int           loads_sent = 0;
  int           steps_seen = 0;
  int           sat_seen = 0;
  int           dzero_seen = 0;
  bit           quiet = 0;
  bit           hold_req = 0;

  function automatic longint clamp32(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic int eff_steps();
    return (iter_reg > MaxSteps) ? MaxSteps : int'(iter_reg);
  endfunction

  // Newton run from start, one expected step per iteration
  task automatic predict_run(int start);
    longint x, p, d, q;
    bit sat;
    int cnt;
    step_result_t r;
    cnt = eff_steps();
    x = start;
    for (int k = 0; k < cnt; k++) begin
      p = 0;
      d = 0;
      sat = 0;
      for (int i = int'(degree_reg); i >= 0; i--) begin
        d = clamp32(qmul(d, x) + p, sat);
        p = clamp32(qmul(p, x) + longint'(coef_mem[i]), sat);
      end
      if (d == 0) begin
        r.status = STAT_DZERO;
      end else begin
        q = clamp32((p * 65536) / d, sat);
        x = clamp32(x - q, sat);
        r.status = sat ? STAT_SAT : STAT_OK;
      end
      r.iterate = int'(x);
      r.step = k[5:0];
      r.last = (k + 1 == cnt);
      pending_steps.push_back(r);
    end
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CfgIdxDegree) degree_reg = val;
    else iter_reg = val;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // one transfer; expectations pushed once the item is taken
  task automatic send_item(logic op, logic [6:0] idx, int coef, int start,
                           bit has_exp, int exp_x, status_t exp_st);
    int gap;
    step_result_t r;
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {start, coef, 1'b0, idx};
    do @(posedge clk); while (!s_axis_tready);
    if (op == OpLoad) begin
      coef_mem[idx] = coef;
      loads_sent++;
    end else begin
      starts_sent++;
      if (has_exp) begin
        for (int k = 0; k < eff_steps(); k++) begin
          r.iterate = exp_x;
          r.step = k[5:0];
          r.last = (k + 1 == eff_steps());
          r.status = exp_st;
          pending_steps.push_back(r);
        end
      end else begin
        predict_run(start);
      end
    end
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int rand_q(bit wide);
    if (wide) return int'($urandom());
    return int'($urandom_range(0, 8 << 16)) - (4 << 16);
  endfunction

  function automatic stim_row_t item_row(logic op, logic [6:0] idx, int coef, int start);
    stim_row_t r;
    r = '{default: 0, exp_st: STAT_OK};
    r.op = op;
    r.idx = idx;
    r.coef = coef;
    r.start = start;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic idx, logic [6:0] val);
    stim_row_t r;
    r = '{default: 0, exp_st: STAT_OK};
    r.is_cfg = 1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic stim_row_t held_row(int start);
    stim_row_t r;
    r = item_row(OpStart, 7'd0, 0, start);
    r.has_exp = 1;
    r.exp_x = start;
    r.exp_st = STAT_DZERO;
    return r;
  endfunction

  // receiver: random stalls, one long hold on request
  initial begin
    int n;
    step_result_t e;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        n = 3000;
        hold_req = 0;
      end else begin
        n = quiet ? 0 : $urandom_range(0, 16);
      end
      if (n > 0) begin
        m_axis_tready <= 0;
        repeat (n) @(posedge clk);
      end
      m_axis_tready <= 1;
      do @(posedge clk); while (!m_axis_tvalid);
      steps_seen++;
      if (pending_steps.size() == 0) begin
        $error("unexpected result transfer: iterate_value %0d", $signed(m_axis_tdata[31:0]));
        errors++;
      end else begin
        e = pending_steps.pop_front();
        if (m_axis_tdata[31:0] !== e.iterate) begin
          $error("iterate_value: expected %0d, got %0d", e.iterate,
                 $signed(m_axis_tdata[31:0]));
          errors++;
        end
        if (m_axis_tdata[37:32] !== e.step) begin
          $error("step_number: expected %0d, got %0d", e.step, m_axis_tdata[37:32]);
          errors++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last_step: expected %0d, got %0d", e.last, m_axis_tlast);
          errors++;
        end
        if (m_axis_tdata[39:38] !== e.status) begin
          $error("step_status: expected %0d, got %0d", e.status, m_axis_tdata[39:38]);
          errors++;
        end
        if (e.status == STAT_SAT) sat_seen++;
        if (e.status == STAT_DZERO) dzero_seen++;
      end
    end
  end

  initial begin
    #250ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [6:0] degs[10] = '{7'd1, 7'd2, 7'd3, 7'd5, 7'd0, 7'd4, 7'd127, 7'd7, 7'd3, 7'd2};
    logic [6:0] iters[10] = '{7'd10, 7'd5, 7'd8, 7'd1, 7'd4, 7'd0, 7'd2, 7'd127, 7'd64, 7'd12};
    stim_row_t row;
    logic op;
    logic [6:0] idx;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // every coefficient written before any run reads it
    for (int i = 0; i < MaxTermsDefault; i++)
      send_item(OpLoad, i[6:0], rand_q($urandom_range(0, 3) == 0), 0, 0, 0, STAT_OK);

    table_rows.push_back(item_row(OpLoad, 7'd0, 32'hFFFE0000, 0));
    table_rows.push_back(item_row(OpLoad, 7'd1, 32'h00010000, 0));
    table_rows.push_back(item_row(OpStart, 7'd0, 0, 0));
    table_rows.push_back(item_row(OpLoad, 7'd1, 32'h7FFFFFFF, 0));
    table_rows.push_back(item_row(OpLoad, 7'd0, 32'h80000000, 0));
    table_rows.push_back(item_row(OpStart, 7'd127, 0, 32'h7FFFFFFF));
    table_rows.push_back(item_row(OpStart, 7'd0, 0, 32'h80000000));
    table_rows.push_back(cfg_row(CfgIdxIter, 7'd1));
    table_rows.push_back(item_row(OpStart, 7'd0, 0, 32'h00050000));
    table_rows.push_back(cfg_row(CfgIdxDegree, 7'd0));
    table_rows.push_back(held_row(32'h00030000));
    table_rows.push_back(cfg_row(CfgIdxIter, 7'd3));
    table_rows.push_back(held_row(32'h80000000));
    table_rows.push_back(cfg_row(CfgIdxDegree, 7'd1));
    table_rows.push_back(item_row(OpLoad, 7'd1, 0, 0));
    table_rows.push_back(held_row(32'h00070000));
    table_rows.push_back(cfg_row(CfgIdxIter, 7'd0));
    table_rows.push_back(item_row(OpStart, 7'd0, 0, 32'h00090000));
    table_rows.push_back(cfg_row(CfgIdxDegree, 7'd2));
    table_rows.push_back(cfg_row(CfgIdxIter, 7'd64));
    table_rows.push_back(item_row(OpLoad, 7'd2, 32'h00010000, 0));
    table_rows.push_back(item_row(OpLoad, 7'd1, 0, 0));
    table_rows.push_back(item_row(OpLoad, 7'd0, 32'hFFFE0000, 0));
    table_rows.push_back(item_row(OpStart, 7'd0, 0, 32'h00010000));
    table_rows.push_back(cfg_row(CfgIdxIter, 7'd127));
    table_rows.push_back(item_row(OpLoad, 7'd2, 32'h7FFFFFFF, 0));
    table_rows.push_back(item_row(OpStart, 7'd0, 0, 32'h40000000));

    foreach (table_rows[i]) begin
      row = table_rows[i];
      if (row.is_cfg) begin
        wait_idle();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_item(row.op, row.idx, row.coef, row.start, row.has_exp, row.exp_x, row.exp_st);
      end
    end

    for (int ph = 0; ph < 10; ph++) begin
      wait_idle();
      write_reg(CfgIdxDegree, degs[ph]);
      write_reg(CfgIdxIter, iters[ph]);
      quiet = (ph % 4 == 1);
      for (int n = 0; n < 12; n++) begin
        if (ph == 2 && n == 8) hold_req = 1;
        op = ($urandom_range(0, 99) < 40) ? OpLoad : OpStart;
        // loads mostly target the live terms
        idx = ($urandom_range(0, 3) != 0) ? 7'($urandom_range(0, degs[ph]))
                                          : 7'($urandom_range(0, 127));
        send_item(op, idx, rand_q($urandom_range(0, 4) == 0),
                  rand_q($urandom_range(0, 4) == 0), 0, 0, STAT_OK);
      end
    end
    s_axis_tvalid <= 0;

    while (pending_steps.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    $display("Covered %0d loads and %0d runs, %0d steps checked", loads_sent, starts_sent,
             steps_seen);
    $display("Steps with zero derivative: %0d, with saturation: %0d", dzero_seen, sat_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
